FILE: src/mexp_pkg.sv
// ----------------------------------------------------------------------------
// mexp_pkg: shared constants, types and helpers
// Constants of the prime 1000000007, the Barrett factor and the request and
// response words between the sequencer and the modular multiplier.
// ----------------------------------------------------------------------------
package mexp_pkg;

   localparam logic [29:0] PRIME     = 30'd1000000007;
   localparam logic [31:0] PRIME_X1  = 32'd1000000007;
   localparam logic [31:0] PRIME_X2  = 32'd2000000014;
   localparam logic [31:0] PRIME_X3  = 32'd3000000021;
   localparam logic [31:0] PRIME_X4  = 32'd4000000028;
   // floor(2^60 / PRIME)
   localparam logic [30:0] BARRETT_M = 31'd1152921496;
   // 2^32 mod PRIME
   localparam logic [29:0] POW32_MOD = 30'd294967268;
   // PRIME - 2, the inverse exponent
   localparam logic [29:0] INV_EXP   = 30'd1000000005;

   typedef struct packed {
      logic        start;
      logic [29:0] a;
      logic [29:0] b;
      logic [31:0] addend;
   } mm_req_type;

   typedef struct packed {
      logic        done;
      logic [29:0] product;
   } mm_rsp_type;

   // Reduce a 32-bit value below 5*PRIME into 0 .. PRIME-1.
   function automatic logic [29:0] mod_small(input logic [31:0] v);
      logic [31:0] r;
      priority if (v >= PRIME_X4) begin
         r = v - PRIME_X4;
      end else if (v >= PRIME_X3) begin
         r = v - PRIME_X3;
      end else if (v >= PRIME_X2) begin
         r = v - PRIME_X2;
      end else if (v >= PRIME_X1) begin
         r = v - PRIME_X1;
      end else begin
         r = v;
      end
      return r[29:0];
   endfunction

endpackage

FILE: src/modular_exponentiation.sv
// ----------------------------------------------------------------------------
// modular_exponentiation: power and inverse modulo 1000000007
// Reduces a signed base to its residue, then runs square-and-multiply over
// the exponent bits, top down, on one shared modular multiplier.
// ----------------------------------------------------------------------------
//  channel | dir | word
//  req     | in  | tdata: base[63:0], exponent[126:64]; tuser: mode
//  rsp     | out | tdata: result[29:0]
//
//  One item at a time; req_tready is high only while the sequencer is idle.
//  Bits down to the top set bit skip the squaring; each lower bit squares
//  the accumulator, and a set lower bit then multiplies it by the base.
//  A finished word waits in an output register and a new word is accepted
//  meanwhile; the next result stalls until it leaves. Sync reset clears state.
// ----------------------------------------------------------------------------
module modular_exponentiation (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [127:0] req_tdata,   // base[63:0], exponent[126:64], zero[127]
   input  logic [0:0]   req_tuser,   // mode[0]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [31:0]  rsp_tdata    // result[29:0], zero[31:30]
);

   typedef enum logic [8:0] {
      ST_IDLE = 9'b000000001,
      ST_RES  = 9'b000000010,
      ST_RESW = 9'b000000100,
      ST_BIT  = 9'b000001000,
      ST_SQW  = 9'b000010000,
      ST_MUL  = 9'b000100000,
      ST_MULW = 9'b001000000,
      ST_NEXT = 9'b010000000,
      ST_DONE = 9'b100000000
   } state_type;

   state_type   state_ff, state_in;
   logic [31:0] mag_hi_ff, mag_hi_in;
   logic [31:0] mag_lo_ff, mag_lo_in;
   logic        neg_ff, neg_in;
   logic [62:0] exp_ff, exp_in;
   logic [5:0]  bit_ff, bit_in;
   logic [29:0] acc_ff, acc_in;
   logic [29:0] base_ff, base_in;
   logic        started_ff, started_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [29:0] rsp_data_ff, rsp_data_in;

   logic [63:0] base_raw;
   logic [63:0] mag;
   logic        exp_bit;

   mexp_pkg::mm_req_type mm_req;
   mexp_pkg::mm_rsp_type mm_rsp;

   mexp_modmul u_modmul (
      .clock  (clock),
      .reset  (reset),
      .mm_req (mm_req),
      .mm_rsp (mm_rsp)
   );

   assign base_raw = req_tdata[63:0];
   // 2^63 magnitude of the most negative base fits unsigned
   assign mag      = base_raw[63] ? (~base_raw + 64'd1) : base_raw;
   assign exp_bit  = exp_ff[bit_ff];

   always_comb begin
      mm_req        = '0;
      state_in      = state_ff;
      mag_hi_in     = mag_hi_ff;
      mag_lo_in     = mag_lo_ff;
      neg_in        = neg_ff;
      exp_in        = exp_ff;
      bit_in        = bit_ff;
      acc_in        = acc_ff;
      base_in       = base_ff;
      started_in    = started_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_tready;
      rsp_data_in   = rsp_data_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               mag_hi_in = mag[63:32];
               mag_lo_in = mag[31:0];
               neg_in    = base_raw[63];
               exp_in    = req_tuser[0] ? {33'd0, mexp_pkg::INV_EXP}
                                        : req_tdata[126:64];
               state_in  = ST_RES;
            end
         end
         ST_RES: begin
            // |base| mod p = (hi mod p) * (2^32 mod p) + lo, reduced
            mm_req.start  = 1'b1;
            mm_req.a      = mexp_pkg::mod_small(mag_hi_ff);
            mm_req.b      = mexp_pkg::POW32_MOD;
            mm_req.addend = mag_lo_ff;
            state_in      = ST_RESW;
         end
         ST_RESW: begin
            if (mm_rsp.done) begin
               base_in    = (neg_ff && (mm_rsp.product != 30'd0))
                            ? (mexp_pkg::PRIME - mm_rsp.product) : mm_rsp.product;
               acc_in     = 30'd1;
               started_in = 1'b0;
               bit_in     = 6'd62;
               state_in   = ST_BIT;
            end
         end
         ST_BIT: begin
            if (started_ff) begin
               mm_req.start = 1'b1;
               mm_req.a     = acc_ff;
               mm_req.b     = acc_ff;
               state_in     = ST_SQW;
            end else begin
               // acc is still one: skip squaring, first set bit loads base
               if (exp_bit) begin
                  acc_in     = base_ff;
                  started_in = 1'b1;
               end
               state_in = ST_NEXT;
            end
         end
         ST_SQW: begin
            if (mm_rsp.done) begin
               acc_in   = mm_rsp.product;
               state_in = exp_bit ? ST_MUL : ST_NEXT;
            end
         end
         ST_MUL: begin
            mm_req.start = 1'b1;
            mm_req.a     = acc_ff;
            mm_req.b     = base_ff;
            state_in     = ST_MULW;
         end
         ST_MULW: begin
            if (mm_rsp.done) begin
               acc_in   = mm_rsp.product;
               state_in = ST_NEXT;
            end
         end
         ST_NEXT: begin
            if (bit_ff == 6'd0) begin
               state_in = ST_DONE;
            end else begin
               bit_in   = bit_ff - 6'd1;
               state_in = ST_BIT;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = acc_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_hi_ff   <= mag_hi_in;
      mag_lo_ff   <= mag_lo_in;
      neg_ff      <= neg_in;
      exp_ff      <= exp_in;
      bit_ff      <= bit_in;
      acc_ff      <= acc_in;
      base_ff     <= base_in;
      started_ff  <= started_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_data_ff};

`ifndef NO_ASSERTIONS
   a_done_expected: assert property (@(posedge clock) disable iff (reset)
      mm_rsp.done |-> (state_ff == ST_RESW || state_ff == ST_SQW ||
                       state_ff == ST_MULW))
      else $error("modmul done outside a wait state");

   a_operands_reduced: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_BIT |-> (acc_ff < mexp_pkg::PRIME) && (base_ff < mexp_pkg::PRIME))
      else $error("operand not reduced");

   a_bit_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_BIT |-> bit_ff <= 6'd62)
      else $error("exponent bit index out of range");

   a_result_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_data_ff < mexp_pkg::PRIME)
      else $error("result not reduced");
`endif

endmodule

FILE: src/mexp_modmul.sv
// ----------------------------------------------------------------------------
// mexp_modmul: multi-cycle modular multiplier
// Computes (a*b + addend) mod PRIME with one shared 32x32 multiplier and a
// Barrett reduction: product, quotient estimate, quotient times prime,
// subtract, final correction.
// ----------------------------------------------------------------------------
module mexp_modmul (
   input  logic                   clock,
   input  logic                   reset,
   input  mexp_pkg::mm_req_type   mm_req,
   output mexp_pkg::mm_rsp_type   mm_rsp
);

   typedef enum logic [4:0] {
      MM_IDLE = 5'b00001,
      MM_QEST = 5'b00010,
      MM_QMUL = 5'b00100,
      MM_SUB  = 5'b01000,
      MM_FIX  = 5'b10000
   } mm_state_type;

   mm_state_type state_ff, state_in;
   logic [61:0]  prod_ff, prod_in;
   logic [31:0]  x_ff, x_in;
   logic [31:0]  r_ff, r_in;
   logic [29:0]  product_ff, product_in;
   logic         done_ff, done_in;

   logic [31:0]  op_a;
   logic [31:0]  op_b;
   logic [31:0]  addend;
   logic [63:0]  mul_sum;

   // the one multiplier, operands selected by step
   always_comb begin
      unique case (state_ff)
         MM_IDLE: begin
            op_a   = {2'b00, mm_req.a};
            op_b   = {2'b00, mm_req.b};
            addend = mm_req.addend;
         end
         MM_QEST: begin
            op_a   = {1'b0, prod_ff[59:29]};
            op_b   = {1'b0, mexp_pkg::BARRETT_M};
            addend = 32'd0;
         end
         MM_QMUL: begin
            op_a   = {1'b0, prod_ff[61:31]};
            op_b   = {2'b00, mexp_pkg::PRIME};
            addend = 32'd0;
         end
         default: begin
            op_a   = 32'd0;
            op_b   = 32'd0;
            addend = 32'd0;
         end
      endcase
      mul_sum = ({32'd0, op_a} * {32'd0, op_b}) + {32'd0, addend};
   end

   always_comb begin
      state_in   = state_ff;
      prod_in    = prod_ff;
      x_in       = x_ff;
      r_in       = r_ff;
      product_in = product_ff;
      done_in    = 1'b0;
      unique case (state_ff)
         MM_IDLE: begin
            if (mm_req.start) begin
               prod_in  = mul_sum[61:0];
               state_in = MM_QEST;
            end
         end
         MM_QEST: begin
            // only the low word of x is needed: the remainder fits 32 bits
            x_in     = prod_ff[31:0];
            prod_in  = mul_sum[61:0];
            state_in = MM_QMUL;
         end
         MM_QMUL: begin
            prod_in  = mul_sum[61:0];
            state_in = MM_SUB;
         end
         MM_SUB: begin
            // quotient low by at most 2, remainder below 3.1*PRIME
            r_in     = x_ff - prod_ff[31:0];
            state_in = MM_FIX;
         end
         MM_FIX: begin
            product_in = mexp_pkg::mod_small(r_ff);
            done_in    = 1'b1;
            state_in   = MM_IDLE;
         end
         default: begin
            state_in = MM_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MM_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff    <= prod_in;
      x_ff       <= x_in;
      r_ff       <= r_in;
      product_ff <= product_in;
   end

   assign mm_rsp.done    = done_ff;
   assign mm_rsp.product = product_ff;

`ifndef NO_ASSERTIONS
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      mm_req.start |-> state_ff == MM_IDLE)
      else $error("modmul started while busy");

   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == MM_FIX |-> r_ff < mexp_pkg::PRIME_X4)
      else $error("Barrett remainder out of bound");

   a_done_range: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> product_ff < mexp_pkg::PRIME)
      else $error("modmul product not reduced");
`endif

endmodule
